### hw/rtl/ipv4_fragment_header_generator_macros.svh
// ----------------------------------------------------------------------------
// IPv4 fragment header generator assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_MACROS_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define IFHG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IFHG_ASSERT_STEP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IFHG_ASSERT(lbl, clk, rst, prop, msg)
`define IFHG_ASSERT_STEP(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/ifhg_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Shared constants and the command word passed from front to back end.
// ----------------------------------------------------------------------------
package ifhg_pkg;

   localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
   localparam logic [13:0] HDR_BYTES   = 14'd20;
   localparam logic [13:0] MTU_MIN     = 14'd1044;
   localparam logic [13:0] MTU_MAX     = 14'd9216;
   localparam logic [13:0] MTU_RESET   = 14'd1500;
   localparam logic [7:0]  VER_IHL     = 8'd69;
   localparam logic [7:0]  TTL_VAL     = 8'd64;
   localparam logic [15:0] ID_RESET    = 16'd1;
   localparam int          QUEUE_DEPTH = 2;

   localparam int          CSR_INDEX_W = 2;
   localparam int          CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_MTU    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDR = 2'd1;

   // base: sum of the header words that stay fixed over a datagram
   typedef struct packed {
      logic [15:0] len;
      logic [13:0] frag;
      logic [15:0] id;
      logic [18:0] base;
   } cmd_type;

endpackage

### hw/rtl/ifhg_front.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator front end
// Accepts requests, checks length, assigns identifier, builds command word.
// ----------------------------------------------------------------------------
module ifhg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [15:0]           req_payload_length,
   input  logic [7:0]            req_upper_protocol,
   input  logic [31:0]           req_dest_address,
   input  logic [13:0]           link_mtu,
   input  logic [31:0]           source_address,
   input  logic                  q_full,
   output logic                  q_push,
   output ifhg_pkg::cmd_type     q_cmd
);
   import ifhg_pkg::*;

   logic [15:0] id_ff, id_in;
   logic [13:0] mtu_c, frag_raw;
   logic        accept, len_ok;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign len_ok    = req_payload_length <= MAX_PAYLOAD;
   assign q_push    = accept && len_ok && (req_payload_length != 16'd0);

   always_comb begin
      if (link_mtu < MTU_MIN) begin
         mtu_c = MTU_MIN;
      end else if (link_mtu > MTU_MAX) begin
         mtu_c = MTU_MAX;
      end else begin
         mtu_c = link_mtu;
      end
      frag_raw = mtu_c - HDR_BYTES;
   end

   always_comb begin
      q_cmd.len  = req_payload_length;
      q_cmd.frag = {frag_raw[13:3], 3'b000};
      q_cmd.id   = id_ff;
      q_cmd.base = 19'({VER_IHL, 8'h00}) + 19'({TTL_VAL, req_upper_protocol})
                 + 19'(source_address[31:16]) + 19'(source_address[15:0])
                 + 19'(req_dest_address[31:16]) + 19'(req_dest_address[15:0])
                 + 19'(id_ff);
      id_in = (accept && len_ok) ? id_ff + 16'd1 : id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= ID_RESET;
      end else begin
         id_ff <= id_in;
      end
   end

endmodule

### hw/rtl/ifhg_queue.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator command queue
// Small register FIFO decoupling front and back end.
// ----------------------------------------------------------------------------
module ifhg_queue #(
   parameter int DEPTH = ifhg_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ifhg_pkg::cmd_type     push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output ifhg_pkg::cmd_type     pop_data
);
   import ifhg_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full      = cnt_ff == FULL_CNT;
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_IDX) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hw/rtl/ifhg_back.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator back end
// Walks one datagram into an output register, one fragment header per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_generator_macros.svh"

module ifhg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ifhg_pkg::cmd_type     q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [13:0]           rsp_total_length,
   output logic [15:0]           rsp_identification,
   output logic [15:0]           rsp_flags_offset,
   output logic [15:0]           rsp_header_checksum,
   output logic [15:0]           rsp_payload_start,
   output logic [13:0]           rsp_payload_bytes,
   output logic                  rsp_last_fragment
);
   import ifhg_pkg::*;

   typedef enum logic {S_IDLE, S_EMIT} state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [15:0] pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [13:0] tot_ff, tot_in, bytes_ff, bytes_in;
   logic [15:0] id_ff, id_in, fo_ff, fo_in, csum_ff, csum_in, start_ff, start_in;
   logic        last_ff, last_in;

   logic [16:0] pos_end;
   logic        last, out_free, emit;
   logic [13:0] bytes, tot;
   logic [15:0] fo, fold2;
   logic [19:0] sum;
   logic [16:0] fold1;

   assign out_free = !valid_ff || rsp_ready;
   assign emit     = (state_ff == S_EMIT) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      pos_end = {1'b0, pos_ff} + 17'(cmd_ff.frag);
      last    = pos_end >= {1'b0, cmd_ff.len};
      bytes   = last ? 14'(cmd_ff.len - pos_ff) : cmd_ff.frag;
      tot     = bytes + HDR_BYTES;
      fo      = {2'b00, !last, pos_ff[15:3]};
      sum     = 20'(cmd_ff.base) + 20'(tot) + 20'(fo);
      fold1   = 17'(sum[15:0]) + 17'(sum[19:16]);
      fold2   = fold1[15:0] + 16'(fold1[16]);
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp_ready;
      tot_in   = tot_ff;
      id_in    = id_ff;
      fo_in    = fo_ff;
      csum_in  = csum_ff;
      start_in = start_ff;
      bytes_in = bytes_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in   = q_cmd;
               pos_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit) begin
               valid_in = 1'b1;
               tot_in   = tot;
               id_in    = cmd_ff.id;
               fo_in    = fo;
               csum_in  = ~fold2;
               start_in = pos_ff;
               bytes_in = bytes;
               last_in  = last;
               pos_in   = pos_end[15:0];
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      pos_ff   <= pos_in;
      tot_ff   <= tot_in;
      id_ff    <= id_in;
      fo_ff    <= fo_in;
      csum_ff  <= csum_in;
      start_ff <= start_in;
      bytes_ff <= bytes_in;
      last_ff  <= last_in;
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_total_length    = tot_ff;
   assign rsp_identification  = id_ff;
   assign rsp_flags_offset    = fo_ff;
   assign rsp_header_checksum = csum_ff;
   assign rsp_payload_start   = start_ff;
   assign rsp_payload_bytes   = bytes_ff;
   assign rsp_last_fragment   = last_ff;

   `IFHG_ASSERT(a_len_sum, clock, reset, valid_ff |-> (tot_ff == bytes_ff + HDR_BYTES), "total length mismatch")
   `IFHG_ASSERT(a_mf_last, clock, reset, valid_ff |-> (fo_ff[13] != last_ff), "MF flag disagrees with last")
   `IFHG_ASSERT(a_pos_in_range, clock, reset, (state_ff == S_EMIT) |-> (pos_ff < cmd_ff.len), "fragment start past end")
   `IFHG_ASSERT_STEP(a_pos_step, clock, reset, emit && !last, (state_ff == S_EMIT) && (pos_ff == $past(pos_end[15:0])), "fragment position did not advance")

endmodule

### hw/rtl/ipv4_fragment_header_generator.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Emits one IPv4 header description per fragment of a requested datagram.
// ----------------------------------------------------------------------------
// Request channel (req_*): payload length, protocol and destination of one
// datagram. Result channel (rsp_*): one word per fragment header, in order,
// the final one flagged by rsp_last_fragment. Config channel (csr_*): index 0
// link MTU, index 1 source address; always ready, write only while idle.
// A request is classified on acceptance: oversized ones are dropped without
// consuming an identifier, empty ones consume one but emit nothing. The rest
// enter a short command queue.
// The back end loads a command from the queue while idle, then emits one header
// per cycle while the output register is free; a datagram has 1 to 64 fragments.
// A request reaches the output through the queue, command and output registers.
// When rsp_ready is low the output register holds; the back end stalls and
// the front keeps accepting until the queue fills.
// Reset: identifier 1, MTU 1500, source address 0, queue and outputs empty.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator #(
   parameter int QUEUE_DEPTH = ifhg_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_payload_length,
   input  logic [7:0]                       req_upper_protocol,
   input  logic [31:0]                      req_dest_address,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [13:0]                      rsp_total_length,
   output logic [15:0]                      rsp_identification,
   output logic [15:0]                      rsp_flags_offset,
   output logic [15:0]                      rsp_header_checksum,
   output logic [15:0]                      rsp_payload_start,
   output logic [13:0]                      rsp_payload_bytes,
   output logic                             rsp_last_fragment,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ifhg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ifhg_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ifhg_pkg::*;

   logic [13:0] link_mtu_ff, link_mtu_in;
   logic [31:0] source_address_ff, source_address_in;
   logic        q_full, q_push, q_pop, q_valid;
   cmd_type     push_cmd, pop_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      link_mtu_in       = link_mtu_ff;
      source_address_in = source_address_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LINK_MTU:    link_mtu_in       = csr_data[13:0];
            CSR_SOURCE_ADDR: source_address_in = csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_mtu_ff       <= MTU_RESET;
         source_address_ff <= '0;
      end else begin
         link_mtu_ff       <= link_mtu_in;
         source_address_ff <= source_address_in;
      end
   end

   ifhg_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_payload_length (req_payload_length),
      .req_upper_protocol (req_upper_protocol),
      .req_dest_address   (req_dest_address),
      .link_mtu           (link_mtu_ff),
      .source_address     (source_address_ff),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_cmd              (push_cmd)
   );

   ifhg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (pop_cmd)
   );

   ifhg_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_cmd               (pop_cmd),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_length    (rsp_total_length),
      .rsp_identification  (rsp_identification),
      .rsp_flags_offset    (rsp_flags_offset),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_payload_bytes   (rsp_payload_bytes),
      .rsp_last_fragment   (rsp_last_fragment)
   );

endmodule

### test/ipv4_fragment_header_generator_test.sv
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Sends datagram requests through a valid/ready driver and predicts the
// fragment headers of each accepted request. A monitor compares every header
// word with the oldest prediction. Phases change the MTU and source address
// between drained runs, including MTU values outside the clamp range, under
// varied idle and stall patterns.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ifhg_pkg::*;

   localparam int unsigned RUN_LIMIT        = 1_000_000;
   localparam int unsigned DRAIN_CYCLES     = 80;
   localparam int unsigned RANDOM_PER_PHASE = 58;

   // unmapped register slots, writes must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [15:0] payload_length;
      logic [7:0]  upper_protocol;
      logic [31:0] dest_address;
   } request_type;

   typedef struct packed {
      logic [13:0] total_length;
      logic [15:0] identification;
      logic [15:0] flags_offset;
      logic [15:0] header_checksum;
      logic [15:0] payload_start;
      logic [13:0] payload_bytes;
      logic        last_fragment;
   } header_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [15:0]            req_payload_length = '0;
   logic [7:0]             req_upper_protocol = '0;
   logic [31:0]            req_dest_address = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [13:0]            rsp_total_length;
   logic [15:0]            rsp_identification;
   logic [15:0]            rsp_flags_offset;
   logic [15:0]            rsp_header_checksum;
   logic [15:0]            rsp_payload_start;
   logic [13:0]            rsp_payload_bytes;
   logic                   rsp_last_fragment;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   request_type pending_requests[$];
   header_type  expected_headers[$];
   request_type in_flight;

   logic [13:0] link_mtu_reg = MTU_RESET;
   logic [31:0] source_address_reg = '0;
   logic [15:0] next_identifier = ID_RESET;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned mismatches = 0;
   int unsigned requests_accepted = 0;
   int unsigned headers_checked = 0;
   int unsigned cycle_count = 0;

   ipv4_fragment_header_generator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_payload_length  (req_payload_length),
      .req_upper_protocol  (req_upper_protocol),
      .req_dest_address    (req_dest_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_length    (rsp_total_length),
      .rsp_identification  (rsp_identification),
      .rsp_flags_offset    (rsp_flags_offset),
      .rsp_header_checksum (rsp_header_checksum),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_payload_bytes   (rsp_payload_bytes),
      .rsp_last_fragment   (rsp_last_fragment),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned fragment_size();
      int unsigned mtu;
      mtu = link_mtu_reg;
      if (mtu < MTU_MIN) mtu = MTU_MIN;
      if (mtu > MTU_MAX) mtu = MTU_MAX;
      return ((mtu - HDR_BYTES) / 8) * 8;
   endfunction

   function automatic logic [15:0] ones_complement_sum(logic [13:0] tot, logic [15:0] id,
                                                       logic [15:0] fo, logic [7:0] proto,
                                                       logic [31:0] dst);
      logic [31:0] s;
      s = {16'd0, VER_IHL, 8'd0} + {18'd0, tot} + {16'd0, id} + {16'd0, fo}
          + {16'd0, TTL_VAL, proto}
          + {16'd0, source_address_reg[31:16]} + {16'd0, source_address_reg[15:0]}
          + {16'd0, dst[31:16]} + {16'd0, dst[15:0]};
      while (s[31:16] != 16'd0)
         s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return ~s[15:0];
   endfunction

   // one header per fragment; empty datagrams still use up an identifier
   function automatic void fragment_datagram(request_type r);
      int unsigned frag, pos, bytes;
      logic        is_last;
      header_type  h;
      if (r.payload_length > MAX_PAYLOAD) return;
      frag = fragment_size();
      pos = 0;
      while (pos < r.payload_length) begin
         is_last = (pos + frag) >= r.payload_length;
         bytes = is_last ? r.payload_length - pos : frag;
         h.total_length = 14'(bytes + HDR_BYTES);
         h.identification = next_identifier;
         h.flags_offset = {2'b00, !is_last, 13'(pos / 8)};
         h.header_checksum = ones_complement_sum(h.total_length, next_identifier,
                                                 h.flags_offset, r.upper_protocol,
                                                 r.dest_address);
         h.payload_start = 16'(pos);
         h.payload_bytes = 14'(bytes);
         h.last_fragment = is_last;
         expected_headers.push_back(h);
         pos += frag;
      end
      next_identifier = next_identifier + 16'd1;
   endfunction

   function automatic void queue_request(logic [15:0] len, logic [7:0] proto,
                                         logic [31:0] dst);
      request_type r;
      r.payload_length = len;
      r.upper_protocol = proto;
      r.dest_address = dst;
      pending_requests.push_back(r);
   endfunction

   function automatic request_type random_request(int unsigned frag);
      request_type r;
      int unsigned pick;
      r.upper_protocol = 8'($urandom);
      r.dest_address = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) begin
         r.payload_length = '0;
      end else if (pick < 14) begin
         r.payload_length = 16'($urandom_range(65535, 65516));
      end else if (pick < 22) begin
         r.payload_length = 16'($urandom_range(MAX_PAYLOAD, 32768));
      end else if (pick < 42) begin
         // around a fragment boundary
         r.payload_length = 16'($urandom_range(4, 1) * frag + $urandom_range(2) - 1);
      end else begin
         r.payload_length = 16'($urandom_range(3 * frag, 1));
      end
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_LINK_MTU) link_mtu_reg = value[13:0];
      else if (idx == CSR_SOURCE_ADDR) source_address_reg = value;
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_headers.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            fragment_datagram(in_flight);
            requests_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_payload_length <= in_flight.payload_length;
               req_upper_protocol <= in_flight.upper_protocol;
               req_dest_address <= in_flight.dest_address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // header monitor
   always @(posedge clock) begin
      header_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            headers_checked++;
            if (expected_headers.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual id %0h offset %0h",
                        $time, rsp_identification, rsp_flags_offset);
               mismatches++;
            end else begin
               want = expected_headers.pop_front();
               compare_field("total_length", 32'(want.total_length), 32'(rsp_total_length));
               compare_field("identification", 32'(want.identification),
                             32'(rsp_identification));
               compare_field("flags_offset", 32'(want.flags_offset), 32'(rsp_flags_offset));
               compare_field("header_checksum", 32'(want.header_checksum),
                             32'(rsp_header_checksum));
               compare_field("payload_start", 32'(want.payload_start),
                             32'(rsp_payload_start));
               compare_field("payload_bytes", 32'(want.payload_bytes),
                             32'(rsp_payload_bytes));
               compare_field("last_fragment", 32'(want.last_fragment),
                             32'(rsp_last_fragment));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("%0t: run limit reached, %0d words still expected", $time,
                  expected_headers.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned frag;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings
      frag = fragment_size();
      queue_request(16'd0, 8'd6, 32'h0A000001);
      queue_request(16'd1, 8'd0, 32'h00000000);
      queue_request(16'd7, 8'd255, 32'hFFFFFFFF);
      queue_request(16'd8, 8'd17, 32'h80000001);
      queue_request(16'(frag - 1), 8'd1, $urandom);
      queue_request(16'(frag), 8'd6, $urandom);
      queue_request(16'(frag + 1), 8'd17, $urandom);
      queue_request(16'(2 * frag), 8'd128, $urandom);
      queue_request(MAX_PAYLOAD, 8'd6, 32'hC0A80001);
      queue_request(MAX_PAYLOAD + 16'd1, 8'd6, 32'h01020304);
      queue_request(16'hFFFF, 8'd255, 32'hFFFFFFFF);
      queue_request(16'd0, 8'd0, 32'h00000000);
      queue_request(16'd1000, 8'd255, 32'h7FFFFFFF);
      queue_request(16'h8000, 8'h55, 32'hAAAAAAAA);
      drain();

      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: begin
               write_register(CSR_LINK_MTU, 32'(MTU_MIN));
               write_register(CSR_SOURCE_ADDR, 32'hFFFFFFFF);
               write_register(CSR_SPARE_A, $urandom);
               send_idle_pct = 62;
               stall_pct = 0;
            end
            2: begin
               write_register(CSR_LINK_MTU, {18'($urandom_range(262143)), MTU_MAX});
               write_register(CSR_SOURCE_ADDR, $urandom);
               write_register(CSR_SPARE_B, $urandom);
               send_idle_pct = 0;
               stall_pct = 62;
            end
            3: begin
               // below the clamp range, upper data bits must not matter
               write_register(CSR_LINK_MTU, {18'($urandom_range(262143)), 14'd0});
               write_register(CSR_SOURCE_ADDR, 32'h0);
               send_idle_pct = 31;
               stall_pct = 31;
            end
            4: begin
               write_register(CSR_LINK_MTU, 32'h3FFF);
               write_register(CSR_SOURCE_ADDR, $urandom);
               send_idle_pct = 0;
               stall_pct = 0;
            end
            default: begin
               write_register(CSR_LINK_MTU, $urandom_range(MTU_MAX, MTU_MIN));
               write_register(CSR_SOURCE_ADDR, $urandom);
               write_register(CSR_SPARE_A, $urandom);
               send_idle_pct = 31;
               stall_pct = 31;
            end
         endcase
         frag = fragment_size();
         queue_request(MAX_PAYLOAD, 8'($urandom), $urandom);
         repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request(frag));
         drain();
      end

      $display("Checked %0d fragment headers from %0d accepted requests,", headers_checked,
               requests_accepted);
      $display("MTU from below to above its clamp range, empty and oversized requests, "
               + "idle and stall mixes.");
      if (mismatches == 0 && expected_headers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
